// ----- hdl/sky_cone_box_region_filter_defines.svh -----
// Assertion macros for the sky region filter.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef SKY_CONE_BOX_REGION_FILTER_DEFINES_SVH
`define SKY_CONE_BOX_REGION_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCBRF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scbrf_pkg.sv -----
// Constants, widths and tables for the sky region filter.
// No dependencies.
`default_nettype none

package scbrf_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int RA_WRAP_TRIES = 4;

  // Datapath widths.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int RED_W     = 39;
  localparam int Z_W       = 34;
  localparam int XY_W      = 34;
  localparam int BOX_W     = 36;
  localparam int NUM_LANES = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_DEC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RA_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RA_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_DEC_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_DEC_END   = 3'd7;

  // Search modes.
  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_CONE = 2'd1;
  localparam logic [1:0] MODE_BOX  = 2'd2;

  // Fixed-point constants (Q30 angles unless noted).
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_GAIN    = 64'sd652032874;
  localparam longint Q26_TWO_PI  = 64'sd421657428;

  localparam logic [RED_W-1:0]      RED_TWO_PI  = RED_W'(Q30_TWO_PI);
  localparam logic [Z_W-1:0]        Z_TWO_PI    = Z_W'(Q30_TWO_PI);
  localparam logic [Z_W-1:0]        Z_PI_U      = Z_W'(Q30_PI);
  localparam logic signed [Z_W-1:0] Z_PI        = Z_W'(Q30_PI);
  localparam logic signed [Z_W-1:0] Z_HALF_PI   = Z_W'(Q30_HALF_PI);
  localparam logic signed [XY_W-1:0] XY_GAIN    = XY_W'(Q30_GAIN);
  localparam logic signed [XY_W-1:0] XY_ONE     = XY_W'(Q30_ONE);
  localparam logic signed [31:0]     UNIT_ONE   = 32'(Q30_ONE);

  // Arctangent of 2^-i in Q30.
  localparam logic [Z_W-1:0] ATAN_HEAD [10] = '{
    34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159, 34'd67021687,
    34'd33543516, 34'd16775851, 34'd8388437, 34'd4194283, 34'd2097149
  };

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic [Z_W-1:0] r;
    r = '0;
    if (i < 10) begin
      r = ATAN_HEAD[4'(i)];
    end else if (i <= 30) begin
      r = Z_W'(64'd1 << (30 - i));
    end
    return $signed(r);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sky_cone_box_region_filter.sv -----
// Sky region filter: cone test by pipelined CORDIC, box test with RA wrap.
// Depends on scbrf_pkg and sky_cone_box_region_filter_defines.svh.
//
// One source word is accepted every clock cycle while the output word is
// empty or taken. The pipeline length is set by the unrolled CORDIC, one
// rotation per register stage, plus angle reduction, saturation and two
// multiply stages.
// When the output word is not taken, the whole pipeline holds in place.
// Configuration is read directly by the datapath, so write it only while
// no word is in flight.
`default_nettype none

module sky_cone_box_region_filter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [31:0]                   source_ra_i,
  input  wire logic signed [31:0]                   source_dec_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      in_region_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [scbrf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [scbrf_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int N  = scbrf_pkg::CORDIC_STAGES;
  localparam int NL = scbrf_pkg::NUM_LANES;

  // Configuration registers.
  logic [1:0]         mode_q;
  logic signed [31:0] center_ra_q, center_dec_q, cos_radius_q;
  logic signed [31:0] box_ra_start_q, box_ra_end_q, box_dec_start_q, box_dec_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= scbrf_pkg::MODE_ALL;
      center_ra_q     <= '0;
      center_dec_q    <= '0;
      cos_radius_q    <= scbrf_pkg::UNIT_ONE;
      box_ra_start_q  <= '0;
      box_ra_end_q    <= '0;
      box_dec_start_q <= '0;
      box_dec_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scbrf_pkg::REG_SEARCH_MODE:   mode_q          <= cfg_data_i[1:0];
        scbrf_pkg::REG_CENTER_RA:     center_ra_q     <= $signed(cfg_data_i);
        scbrf_pkg::REG_CENTER_DEC:    center_dec_q    <= $signed(cfg_data_i);
        scbrf_pkg::REG_COS_RADIUS:    cos_radius_q    <= $signed(cfg_data_i);
        scbrf_pkg::REG_BOX_RA_START:  box_ra_start_q  <= $signed(cfg_data_i);
        scbrf_pkg::REG_BOX_RA_END:    box_ra_end_q    <= $signed(cfg_data_i);
        scbrf_pkg::REG_BOX_DEC_START: box_dec_start_q <= $signed(cfg_data_i);
        scbrf_pkg::REG_BOX_DEC_END:   box_dec_end_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output is empty or taken.
  logic en;
  logic out_v_q;
  logic out_q;
  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign in_region_o = out_q;

  // Pipeline valid bits.
  logic s0_v_q, s1_v_q, s2_v_q;
  logic cv_q [N+1];
  logic sat_v_q, p1_v_q, p2_v_q;

  // Payload registers.
  logic signed [31:0] ra0_q, dec0_q;
  logic [scbrf_pkg::RED_W-1:0] r1_q [NL];
  logic [scbrf_pkg::Z_W-1:0]   r2_q [NL];
  logic box1_q, box2_q;
  logic signed [scbrf_pkg::XY_W-1:0] cx_q [N+1][NL];
  logic signed [scbrf_pkg::XY_W-1:0] cy_q [N+1][NL];
  logic signed [scbrf_pkg::Z_W-1:0]  cz_q [N+1][NL];
  logic cf_q [N+1][NL];
  logic cb_q [N+1];
  logic signed [31:0] sc_q, cc_q, ss_q, cs_q, cd_q;
  logic box_s_q, box_p1_q, box_p2_q;
  logic signed [63:0] p1_q, pcc_q, p1b_q, p3_q;
  logic signed [31:0] cd1_q;

  // First reduction half: scale to Q30, offset positive, remove 32, 16, 8 turns.
  logic signed [32:0]             dra;
  logic signed [scbrf_pkg::RED_W-1:0] a_in [NL];
  logic [scbrf_pkg::RED_W-1:0]    r1_d [NL];
  always_comb begin
    dra     = 33'(center_ra_q) - 33'(ra0_q);
    a_in[0] = scbrf_pkg::RED_W'(center_dec_q) <<< 4;
    a_in[1] = scbrf_pkg::RED_W'(dec0_q) <<< 4;
    a_in[2] = scbrf_pkg::RED_W'(dra) <<< 4;
    for (int l = 0; l < NL; l++) begin
      r1_d[l] = $unsigned(a_in[l]) + (scbrf_pkg::RED_TWO_PI << 5);
      for (int k = 5; k >= 3; k--) begin
        if (r1_d[l] >= (scbrf_pkg::RED_TWO_PI << k)) begin
          r1_d[l] = r1_d[l] - (scbrf_pkg::RED_TWO_PI << k);
        end
      end
    end
  end

  // Box test on the raw source position, tried at each RA wrap.
  logic signed [scbrf_pkg::BOX_W-1:0] cand;
  logic ra_hit, box1_d;
  always_comb begin
    ra_hit = 1'b0;
    for (int t = 0; t < scbrf_pkg::RA_WRAP_TRIES; t++) begin
      cand = scbrf_pkg::BOX_W'(ra0_q)
           + scbrf_pkg::BOX_W'(longint'(t - 1) * scbrf_pkg::Q26_TWO_PI);
      if (cand >= scbrf_pkg::BOX_W'(box_ra_start_q) &&
          cand <= scbrf_pkg::BOX_W'(box_ra_end_q)) begin
        ra_hit = 1'b1;
      end
    end
    box1_d = ra_hit && (dec0_q >= box_dec_start_q) && (dec0_q <= box_dec_end_q);
  end

  // Second reduction half: remove 4, 2, 1 turns, leaving [0, 2pi).
  logic [scbrf_pkg::RED_W-1:0] u2 [NL];
  logic [scbrf_pkg::Z_W-1:0]   r2_d [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      u2[l] = r1_q[l];
      for (int k = 2; k >= 0; k--) begin
        if (u2[l] >= (scbrf_pkg::RED_TWO_PI << k)) begin
          u2[l] = u2[l] - (scbrf_pkg::RED_TWO_PI << k);
        end
      end
      r2_d[l] = u2[l][scbrf_pkg::Z_W-1:0];
    end
  end

  // Center into (-pi, pi] and fold into [-pi/2, pi/2].
  logic signed [scbrf_pkg::Z_W-1:0] rs [NL];
  logic signed [scbrf_pkg::Z_W-1:0] z0_d [NL];
  logic f0_d [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (r2_q[l] > scbrf_pkg::Z_PI_U) begin
        rs[l] = $signed(r2_q[l] - scbrf_pkg::Z_TWO_PI);
      end else begin
        rs[l] = $signed(r2_q[l]);
      end
      f0_d[l] = 1'b0;
      z0_d[l] = rs[l];
      if (rs[l] > scbrf_pkg::Z_HALF_PI) begin
        z0_d[l] = scbrf_pkg::Z_PI - rs[l];
        f0_d[l] = 1'b1;
      end else if (rs[l] < -scbrf_pkg::Z_HALF_PI) begin
        z0_d[l] = -scbrf_pkg::Z_PI - rs[l];
        f0_d[l] = 1'b1;
      end
    end
  end

  // CORDIC rotations, one per stage.
  logic signed [scbrf_pkg::XY_W-1:0] cx_d [N][NL];
  logic signed [scbrf_pkg::XY_W-1:0] cy_d [N][NL];
  logic signed [scbrf_pkg::Z_W-1:0]  cz_d [N][NL];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < NL; l++) begin
        if (cz_q[i][l] >= 0) begin
          cx_d[i][l] = cx_q[i][l] - (cy_q[i][l] >>> i);
          cy_d[i][l] = cy_q[i][l] + (cx_q[i][l] >>> i);
          cz_d[i][l] = cz_q[i][l] - scbrf_pkg::atan_q30(i);
        end else begin
          cx_d[i][l] = cx_q[i][l] + (cy_q[i][l] >>> i);
          cy_d[i][l] = cy_q[i][l] - (cx_q[i][l] >>> i);
          cz_d[i][l] = cz_q[i][l] + scbrf_pkg::atan_q30(i);
        end
      end
    end
  end

  // Saturate to the unit range.
  function automatic logic signed [31:0] sat_unit(input logic signed [scbrf_pkg::XY_W-1:0] v);
    logic signed [31:0] r;
    r = 32'(v);
    if (v > scbrf_pkg::XY_ONE) begin
      r = scbrf_pkg::UNIT_ONE;
    end else if (v < -scbrf_pkg::XY_ONE) begin
      r = -scbrf_pkg::UNIT_ONE;
    end
    return r;
  endfunction

  logic signed [31:0] cos0, cos1, cos2;
  assign cos0 = sat_unit(cx_q[N][0]);
  assign cos1 = sat_unit(cx_q[N][1]);
  assign cos2 = sat_unit(cx_q[N][2]);

  // Cone sum and final verdict.
  logic signed [31:0] t32;
  logic signed [63:0] lhs, rhs;
  logic cone_hit, out_d;
  always_comb begin
    t32      = 32'(pcc_q >>> 30);
    lhs      = 64'(cos_radius_q) <<< 30;
    rhs      = p1b_q + p3_q;
    cone_hit = (lhs <= rhs);
    case (mode_q)
      scbrf_pkg::MODE_ALL:  out_d = 1'b1;
      scbrf_pkg::MODE_CONE: out_d = cone_hit;
      scbrf_pkg::MODE_BOX:  out_d = box_p2_q;
      default:              out_d = 1'b0;
    endcase
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      for (int i = 0; i <= N; i++) begin
        cv_q[i] <= 1'b0;
      end
      sat_v_q <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q  <= in_valid_i;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= s1_v_q;
      cv_q[0] <= s2_v_q;
      for (int i = 0; i < N; i++) begin
        cv_q[i+1] <= cv_q[i];
      end
      sat_v_q <= cv_q[N];
      p1_v_q  <= sat_v_q;
      p2_v_q  <= p1_v_q;
      out_v_q <= p2_v_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ra0_q  <= source_ra_i;
      dec0_q <= source_dec_i;
      r1_q   <= r1_d;
      box1_q <= box1_d;
      r2_q   <= r2_d;
      box2_q <= box1_q;
      for (int l = 0; l < NL; l++) begin
        cx_q[0][l] <= scbrf_pkg::XY_GAIN;
        cy_q[0][l] <= '0;
        cz_q[0][l] <= z0_d[l];
        cf_q[0][l] <= f0_d[l];
      end
      cb_q[0] <= box2_q;
      for (int i = 0; i < N; i++) begin
        for (int l = 0; l < NL; l++) begin
          cx_q[i+1][l] <= cx_d[i][l];
          cy_q[i+1][l] <= cy_d[i][l];
          cz_q[i+1][l] <= cz_d[i][l];
          cf_q[i+1][l] <= cf_q[i][l];
        end
        cb_q[i+1] <= cb_q[i];
      end
      sc_q     <= sat_unit(cy_q[N][0]);
      cc_q     <= cf_q[N][0] ? -cos0 : cos0;
      ss_q     <= sat_unit(cy_q[N][1]);
      cs_q     <= cf_q[N][1] ? -cos1 : cos1;
      cd_q     <= cf_q[N][2] ? -cos2 : cos2;
      box_s_q  <= cb_q[N];
      p1_q     <= 64'(sc_q) * 64'(ss_q);
      pcc_q    <= 64'(cc_q) * 64'(cs_q);
      cd1_q    <= cd_q;
      box_p1_q <= box_s_q;
      p1b_q    <= p1_q;
      p3_q     <= 64'(t32) * 64'(cd1_q);
      box_p2_q <= box_p1_q;
      out_q    <= out_d;
    end
  end

  // Checks on the pipeline.
`include "sky_cone_box_region_filter_defines.svh"

  `SCBRF_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, s0_v_q, "accepted word lost at entry")
  `SCBRF_ASSERT_IMPLIES(a_fold_range, cv_q[0], cz_q[0][2] <= scbrf_pkg::Z_HALF_PI && cz_q[0][2] >= -scbrf_pkg::Z_HALF_PI, "folded angle out of range")
  `SCBRF_ASSERT_IMPLIES(a_cos_range, sat_v_q, cd_q <= scbrf_pkg::UNIT_ONE && cd_q >= -scbrf_pkg::UNIT_ONE, "cosine beyond unit range")

endmodule

`default_nettype wire

// ----- sim/sky_cone_box_region_filter_test.sv -----
// Testbench for the sky region filter: directed and random source words,
// checked against a fixed-point predictor of the cone and box tests.
// Depends on scbrf_pkg and the sky_cone_box_region_filter RTL.
`timescale 1ns / 1ps

// Holds the expected verdicts in order and compares the block's output.
class region_scoreboard;
  bit verdicts_due[$];
  int mismatches;

  function void note_source(bit verdict);
    verdicts_due = {verdicts_due, verdict};
  endfunction

  // Prints one line per mismatch and counts it.
  task report(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task check_verdict(bit got);
    bit want;
    if (verdicts_due.size() == 0) begin
      report($sformatf("verdict %0d with none expected", got));
    end else begin
      want = verdicts_due.pop_front();
      if (want != got) begin
        report($sformatf("in_region got %0d want %0d", got, want));
      end
    end
  endtask
endclass

module sky_cone_box_region_filter_test;

  // Search mode code with no meaning; the block answers 0.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] source_ra_i = '0;
  logic signed [31:0] source_dec_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic in_region_o;
  logic cfg_we_i = 1'b0;
  logic [scbrf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [scbrf_pkg::CFG_W-1:0] cfg_data_i = '0;

  region_scoreboard board = new();

  // Predictor copy of the configuration.
  logic [1:0] mode_q = scbrf_pkg::MODE_ALL;
  longint cra_q = 0, cdec_q = 0, cosr_q = scbrf_pkg::Q30_ONE;
  longint bras_q = 0, brae_q = 0, bdecs_q = 0, bdece_q = 0;

  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  sky_cone_box_region_filter i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Generous limit for the whole run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > scbrf_pkg::Q30_ONE) return scbrf_pkg::Q30_ONE;
    if (v < -scbrf_pkg::Q30_ONE) return -scbrf_pkg::Q30_ONE;
    return v;
  endfunction

  // Sine and cosine of a Q30 angle by a CORDIC rotation.
  task automatic rotate_angle(input longint angle, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy, a;
    bit flip;
    r = angle % scbrf_pkg::Q30_TWO_PI;
    x = scbrf_pkg::Q30_GAIN; y = 0; flip = 0;
    if (r < 0) r += scbrf_pkg::Q30_TWO_PI;
    if (r > scbrf_pkg::Q30_PI) r -= scbrf_pkg::Q30_TWO_PI;
    if (r > scbrf_pkg::Q30_HALF_PI) begin
      r = scbrf_pkg::Q30_PI - r; flip = 1;
    end else if (r < -scbrf_pkg::Q30_HALF_PI) begin
      r = -scbrf_pkg::Q30_PI - r; flip = 1;
    end
    z = r;
    for (int i = 0; i < scbrf_pkg::CORDIC_STAGES; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      a = (i < 10) ? longint'(scbrf_pkg::ATAN_HEAD[i]) :
          (i <= 30) ? (64'sd1 << (30 - i)) : 0;
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    sn = clamp_unit(y);
    cs = flip ? -clamp_unit(x) : clamp_unit(x);
  endtask

  task automatic predict_region(input longint ra, input longint dec, output bit hit);
    longint sc, cc, ss, cs, sd, cd, cand;
    bit ra_ok;
    ra_ok = 0;
    case (mode_q)
      scbrf_pkg::MODE_ALL: hit = 1;
      scbrf_pkg::MODE_CONE: begin
        rotate_angle(cdec_q * 16, sc, cc);
        rotate_angle(dec * 16, ss, cs);
        rotate_angle((cra_q - ra) * 16, sd, cd);
        hit = (cosr_q * scbrf_pkg::Q30_ONE) <= (sc * ss + floor_sh(cc * cs, 30) * cd);
      end
      scbrf_pkg::MODE_BOX: begin
        for (int t = 0; t < scbrf_pkg::RA_WRAP_TRIES; t++) begin
          cand = ra + longint'(t - 1) * scbrf_pkg::Q26_TWO_PI;
          if (cand >= bras_q && cand <= brae_q) ra_ok = 1;
        end
        hit = ra_ok && dec >= bdecs_q && dec <= bdece_q;
      end
      default: hit = 0;
    endcase
  endtask

  task automatic write_reg(input logic [scbrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      scbrf_pkg::REG_SEARCH_MODE: mode_q = value[1:0];
      scbrf_pkg::REG_CENTER_RA: cra_q = longint'($signed(value));
      scbrf_pkg::REG_CENTER_DEC: cdec_q = longint'($signed(value));
      scbrf_pkg::REG_COS_RADIUS: cosr_q = longint'($signed(value));
      scbrf_pkg::REG_BOX_RA_START: bras_q = longint'($signed(value));
      scbrf_pkg::REG_BOX_RA_END: brae_q = longint'($signed(value));
      scbrf_pkg::REG_BOX_DEC_START: bdecs_q = longint'($signed(value));
      scbrf_pkg::REG_BOX_DEC_END: bdece_q = longint'($signed(value));
      default: ;
    endcase
  endtask

  // Stop offering, wait until every verdict has come, then let the pipeline drain.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk_i);
    repeat (scbrf_pkg::CORDIC_STAGES + 20) @(negedge clk_i);
  endtask

  // Offer one source word and hold it until accepted; valid stays high on return.
  task automatic send_source(input logic [31:0] ra, input logic [31:0] dec);
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; source_ra_i <= ra; source_dec_i <= dec;
    predict_region(longint'($signed(ra)), longint'($signed(dec)), hit);
    do @(posedge clk_i); while (!in_ready_o);
    board.note_source(hit);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(in_region_o);
  end

  task automatic near_angle(output logic [31:0] v);
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) v = $urandom;
    else if (pick == 1) v = $urandom_range(0, 210828714) - 105414357;
    else if (pick == 2) v = 32'(cra_q + longint'($urandom_range(0, 20000000)) - 10000000);
    else v = 32'($signed($urandom_range(0, 843314856))) - 421657428;
  endtask

  task automatic random_setting(input logic [1:0] kind);
    logic [31:0] a, b;
    write_reg(scbrf_pkg::REG_SEARCH_MODE, 32'(kind));
    write_reg(scbrf_pkg::REG_CENTER_RA, $urandom_range(0, 421657428) - 210828714);
    write_reg(scbrf_pkg::REG_CENTER_DEC, $urandom_range(0, 210828714) - 105414357);
    write_reg(scbrf_pkg::REG_COS_RADIUS, $urandom_range(0, 2147483647) - 1073741824);
    a = $urandom_range(0, 843314856) - 421657428;
    b = a + $urandom_range(0, 200000000);
    write_reg(scbrf_pkg::REG_BOX_RA_START, a);
    write_reg(scbrf_pkg::REG_BOX_RA_END, b);
    a = $urandom_range(0, 210828714) - 105414357;
    write_reg(scbrf_pkg::REG_BOX_DEC_START, a);
    write_reg(scbrf_pkg::REG_BOX_DEC_END, a + $urandom_range(0, 80000000));
  endtask

  initial begin
    logic [31:0] ra, dec;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes in pass-all, cone, box, empty window and mode three.
    send_source(32'h8000_0000, 32'h7fff_ffff);
    send_source(32'h7fff_ffff, 32'h8000_0000);
    drain();
    write_reg(scbrf_pkg::REG_SEARCH_MODE, 32'(scbrf_pkg::MODE_CONE));
    write_reg(scbrf_pkg::REG_CENTER_RA, 32'h7fff_ffff);
    write_reg(scbrf_pkg::REG_CENTER_DEC, 32'h8000_0000);
    write_reg(scbrf_pkg::REG_COS_RADIUS, 32'h8000_0000);
    send_source(32'h8000_0000, 32'h8000_0000);
    send_source(32'h0, 32'hffff_ffff);
    drain();
    write_reg(scbrf_pkg::REG_COS_RADIUS, 32'h7fff_ffff);
    send_source(32'h7fff_ffff, 32'h8000_0000);
    drain();
    write_reg(scbrf_pkg::REG_CENTER_RA, 0);
    write_reg(scbrf_pkg::REG_CENTER_DEC, 0);
    write_reg(scbrf_pkg::REG_COS_RADIUS, 32'd1073741824);
    send_source(0, 0);
    drain();
    write_reg(scbrf_pkg::REG_COS_RADIUS, 32'hc000_0000);
    send_source(32'd210828714, 32'd10);
    drain();
    write_reg(scbrf_pkg::REG_SEARCH_MODE, 32'(scbrf_pkg::MODE_BOX));
    write_reg(scbrf_pkg::REG_BOX_RA_START, 32'h8000_0000);
    write_reg(scbrf_pkg::REG_BOX_RA_END, 32'h7fff_ffff);
    write_reg(scbrf_pkg::REG_BOX_DEC_START, 32'h8000_0000);
    write_reg(scbrf_pkg::REG_BOX_DEC_END, 32'h7fff_ffff);
    send_source(32'h8000_0000, 32'h7fff_ffff);
    send_source(32'h7fff_ffff, 32'h8000_0000);
    drain();
    write_reg(scbrf_pkg::REG_BOX_RA_START, 32'd100);
    write_reg(scbrf_pkg::REG_BOX_RA_END, 32'd200);
    write_reg(scbrf_pkg::REG_BOX_DEC_START, 32'd0);
    write_reg(scbrf_pkg::REG_BOX_DEC_END, 32'd50);
    send_source(32'd100, 32'd0);
    send_source(32'd200, 32'd50);
    send_source(32'd201, 32'd50);
    send_source(32'd100 - 32'd421657428, 32'd51);
    send_source(32'd150 - 32'd421657428, 32'd10);
    send_source(32'd150 - 32'd843314856, 32'd10);
    send_source(32'd150 + 32'd421657428, 32'd10);
    drain();
    // Empty window: start above end.
    write_reg(scbrf_pkg::REG_BOX_RA_START, 32'd300);
    send_source(32'd250, 32'd10);
    drain();
    write_reg(scbrf_pkg::REG_SEARCH_MODE, 32'(MODE_UNUSED));
    send_source(32'd150, 32'd10);
    drain();

    // Random phases with changing idle shares and settings.
    for (int ph = 0; ph < 18; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 27 : (ph % 3 == 1) ? 73 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 73 : (ph % 3 == 1) ? 27 : 0;
      random_setting((ph % 7 == 6) ? MODE_UNUSED : 2'(ph % 3));
      if (ph == 4) begin
        // Hold the receiver off long enough for the pipeline to fill.
        fork
          begin
            recv_hold = 1'b1;
            repeat (200) @(negedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 96; k++) begin
        near_angle(ra);
        near_angle(dec);
        if (mode_q == scbrf_pkg::MODE_BOX && $urandom_range(1)) begin
          ra = 32'(bras_q) + $urandom_range(0, 200000000) +
               32'(longint'($urandom_range(0, 3)) - 1) * 32'd421657428;
          dec = 32'(bdecs_q) + $urandom_range(0, 80000000);
        end
        send_source(ra, dec);
        // Once, midway through phase seven, pause until every verdict is back.
        if (k == 48 && ph == 7) begin
          in_valid_i <= 1'b0;
          while (board.verdicts_due.size() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
